// ----- rtl/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants for the NTC ADC-to-temperature unit
// Widths, register map, resistance table and the divider request word.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int ADC_FULL_SCALE = 4095;
  localparam int TABLE_ENTRIES  = 34;
  localparam int ROM_WORDS      = 34;
  localparam int N_USED = (TABLE_ENTRIES > ROM_WORDS) ? ROM_WORDS :
                          ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);

  localparam int CODE_W  = 12;
  localparam int START_W = 12;
  localparam int STEP_W  = 9;
  localparam int SRES_W  = 17;
  localparam int TEMP_W  = 15;
  localparam int R_W     = SRES_W + CODE_W;
  localparam int ROM_W   = 18;
  localparam int DIV_W   = 16;
  localparam int CNT_W   = $clog2(R_W + 1);
  localparam int IDX_W   = $clog2(ROM_WORDS);
  localparam int MA_W    = 18;
  localparam int MB_W    = 13;
  localparam int MP_W    = MA_W + MB_W;
  localparam int ALPHA_W = 10;

  localparam int FRAC_SCALE  = 1000;
  // quotient bounds: alpha <= 1000, |alpha*step|/1000 <= 256
  localparam int ALPHA_STEPS = 10;
  localparam int SCALE_STEPS = 9;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic signed [START_W-1:0] TEMP_START_RST = START_W'(1250);
  localparam logic signed [STEP_W-1:0]  TEMP_STEP_RST  = STEP_W'(-50);
  localparam logic [SRES_W-1:0]         SERIES_RES_RST = SRES_W'(10000);

  typedef enum logic [1:0] {
    REG_TEMP_START = 2'd0,
    REG_TEMP_STEP  = 2'd1,
    REG_SERIES_RES = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [START_W-1:0] temp_start;
    logic signed [STEP_W-1:0]  temp_step;
    logic [SRES_W-1:0]         series_res;
  } cfg_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  // ascending thermistor resistance in ohms, one entry per temp_step
  function automatic logic [ROM_W-1:0] rom_word(input logic [IDX_W-1:0] idx);
    logic [ROM_W-1:0] w;
    case (idx)
      6'd0:  w = 18'd531;
      6'd1:  w = 18'd596;
      6'd2:  w = 18'd672;
      6'd3:  w = 18'd758;
      6'd4:  w = 18'd858;
      6'd5:  w = 18'd974;
      6'd6:  w = 18'd1110;
      6'd7:  w = 18'd1268;
      6'd8:  w = 18'd1452;
      6'd9:  w = 18'd1669;
      6'd10: w = 18'd1925;
      6'd11: w = 18'd2228;
      6'd12: w = 18'd2586;
      6'd13: w = 18'd3014;
      6'd14: w = 18'd3535;
      6'd15: w = 18'd4161;
      6'd16: w = 18'd4917;
      6'd17: w = 18'd5834;
      6'd18: w = 18'd6948;
      6'd19: w = 18'd8315;
      6'd20: w = 18'd10000;
      6'd21: w = 18'd12081;
      6'd22: w = 18'd14674;
      6'd23: w = 18'd17926;
      6'd24: w = 18'd22021;
      6'd25: w = 18'd27219;
      6'd26: w = 18'd33892;
      6'd27: w = 18'd42506;
      6'd28: w = 18'd53650;
      6'd29: w = 18'd68237;
      6'd30: w = 18'd87559;
      6'd31: w = 18'd113347;
      6'd32: w = 18'd148171;
      6'd33: w = 18'd195652;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/ntc_adc_to_temperature_unit.sv -----
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_unit: NTC thermistor ADC code to temperature
// Resistance from the divider equation, table walk and linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive adc_code_i and pulse start while busy is low; the word is
//   taken at that edge and busy rises on the next cycle.
//   Output: one result word per input, shown for exactly one cycle with
//   result_valid_o high (temperature_tenths_o, clamped_o). busy drops in the
//   same cycle, so the next start may be given while the result is shown.
//   The receiver cannot stall; it must take the word in that cycle.
//   Flow: a code below full scale divides for the resistance; a code at full
//   scale skips the division and takes series_res times the code. A resistance
//   off the table clamps low or high; else the table walk and interpolation
//   follow, and the unit takes no new word until the result is shown. The work
//   rests on the one shared restoring divider (29 bits for the resistance, 10
//   for the fraction, 9 for the scaling by 1/1000) and on the table walk of one
//   entry per cycle; a single registered multiplier serves all products.
//   Configuration: APB writes must be made only while the unit is idle; the
//   unit does not enforce it, and pready is always high.
//   Reset: registers return to their defaults (1250, -50, 10000) and the
//   unit comes up idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ntc_pkg::CODE_W-1:0]         adc_code_i,
  output logic                               result_valid_o,
  output logic signed [ntc_pkg::TEMP_W-1:0]  temperature_tenths_o,
  output logic                               clamped_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ntc_pkg::APB_AW-1:0]         paddr,
  input  logic [ntc_pkg::APB_DW-1:0]         pwdata,
  output logic [ntc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import ntc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_R,
    S_SEL_R,
    S_DIV_R,
    S_CMP,
    S_MUL_HI,
    S_HI_ADD,
    S_WALK,
    S_MUL_F,
    S_GO_A,
    S_DIV_A,
    S_MUL_S,
    S_GO_S,
    S_DIV_S
  } state_e;

  cfg_t cfg;

  state_e state_q, state_d;
  logic                      valid_q, valid_d;
  logic signed [TEMP_W-1:0]  temp_q, temp_d;
  logic                      clamp_q, clamp_d;

  logic [CODE_W-1:0]         code_q;
  logic [R_W-1:0]            r_q, r_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic signed [TEMP_W-1:0]  base_q, base_d;
  logic [ALPHA_W-1:0]        alpha_q, alpha_d;
  logic                      neg_q, neg_d;
  logic signed [MP_W-1:0]    prod_q, prod_d;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [MP_W-1:0]    mul_ax, mul_bx;

  div_req_t                  div_req;
  logic [R_W-1:0]            div_dividend;
  logic [DIV_W-1:0]          div_divisor;
  logic                      div_done;
  logic [R_W-1:0]            div_quo;

  logic [ROM_W-1:0]          rom_hi, rom_lo;
  logic [IDX_W-1:0]          idx_prev;
  logic signed [TEMP_W-1:0]  start_x, step_x, frac_x;
  logic [MP_W-1:0]           prod_mag;
  logic                      code_in_range;

  ntc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ntc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign idx_prev      = idx_q - IDX_W'(1);
  assign rom_hi        = rom_word(idx_q);
  assign rom_lo        = rom_word(idx_prev);
  assign start_x       = TEMP_W'(cfg.temp_start);
  assign step_x        = TEMP_W'(cfg.temp_step);
  assign frac_x        = TEMP_W'(div_quo[SCALE_STEPS-1:0]);
  assign prod_mag      = prod_q[MP_W-1] ? MP_W'(-prod_q) : MP_W'(prod_q);
  assign code_in_range = (DIV_W'(code_q) < DIV_W'(ADC_FULL_SCALE));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_R: begin
        mul_a = MA_W'(cfg.series_res);
        mul_b = MB_W'(code_q);
      end
      S_MUL_HI: begin
        mul_a = MA_W'(N_USED - 1);
        mul_b = MB_W'(cfg.temp_step);
      end
      S_MUL_F: begin
        mul_a = MA_W'(r_q[ROM_W-1:0] - rom_lo);
        mul_b = MB_W'(FRAC_SCALE);
      end
      S_MUL_S: begin
        mul_a = MA_W'(alpha_q);
        mul_b = MB_W'(cfg.temp_step);
      end
      default: ;
    endcase
  end

  assign mul_ax = MP_W'(mul_a);
  assign mul_bx = MP_W'(mul_b);
  assign prod_d = mul_ax * mul_bx;

  // divider request select
  always_comb begin
    div_req.go    = 1'b0;
    div_req.steps = CNT_W'(R_W);
    div_dividend  = prod_q[R_W-1:0];
    div_divisor   = DIV_W'(ADC_FULL_SCALE) - DIV_W'(code_q);
    case (state_q)
      S_SEL_R: div_req.go = code_in_range;
      S_GO_A: begin
        div_req.go    = 1'b1;
        div_req.steps = CNT_W'(ALPHA_STEPS);
        div_divisor   = DIV_W'(rom_hi - rom_lo);
      end
      S_GO_S: begin
        div_req.go    = 1'b1;
        div_req.steps = CNT_W'(SCALE_STEPS);
        div_dividend  = prod_mag[R_W-1:0];
        div_divisor   = DIV_W'(FRAC_SCALE);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    temp_d  = temp_q;
    clamp_d = clamp_q;
    r_d     = r_q;
    idx_d   = idx_q;
    base_d  = base_q;
    alpha_d = alpha_q;
    neg_d   = neg_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_MUL_R;
        end
      end
      S_MUL_R: state_d = S_SEL_R;
      S_SEL_R: begin
        if (code_in_range) begin
          state_d = S_DIV_R;
        end else begin
          r_d     = prod_q[R_W-1:0];
          state_d = S_CMP;
        end
      end
      S_DIV_R: begin
        if (div_done) begin
          r_d     = div_quo;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (r_q < R_W'(rom_word(IDX_W'(0)))) begin
          valid_d = 1'b1;
          temp_d  = start_x;
          clamp_d = 1'b1;
          state_d = S_IDLE;
        end else if (r_q > R_W'(rom_word(IDX_W'(N_USED - 1)))) begin
          state_d = S_MUL_HI;
        end else begin
          idx_d   = IDX_W'(1);
          base_d  = start_x;
          state_d = S_WALK;
        end
      end
      S_MUL_HI: state_d = S_HI_ADD;
      S_HI_ADD: begin
        valid_d = 1'b1;
        temp_d  = start_x + prod_q[TEMP_W-1:0];
        clamp_d = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK: begin
        // base tracks start + (idx-1)*step
        if ((idx_q < IDX_W'(N_USED - 1)) && (r_q > R_W'(rom_hi))) begin
          idx_d  = idx_q + IDX_W'(1);
          base_d = base_q + step_x;
        end else begin
          state_d = S_MUL_F;
        end
      end
      S_MUL_F: state_d = S_GO_A;
      S_GO_A:  state_d = S_DIV_A;
      S_DIV_A: begin
        if (div_done) begin
          alpha_d = div_quo[ALPHA_W-1:0];
          state_d = S_MUL_S;
        end
      end
      S_MUL_S: state_d = S_GO_S;
      S_GO_S: begin
        neg_d   = prod_q[MP_W-1];
        state_d = S_DIV_S;
      end
      S_DIV_S: begin
        if (div_done) begin
          valid_d = 1'b1;
          temp_d  = neg_q ? (base_q - frac_x) : (base_q + frac_x);
          clamp_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      temp_q  <= '0;
      clamp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      temp_q  <= temp_d;
      clamp_q <= clamp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      code_q <= adc_code_i;
    end
    r_q     <= r_d;
    idx_q   <= idx_d;
    base_q  <= base_d;
    alpha_q <= alpha_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
  end

  assign busy                 = (state_q != S_IDLE);
  assign result_valid_o       = valid_q;
  assign temperature_tenths_o = temp_q;
  assign clamped_o            = clamp_q;

endmodule

// ----- rtl/ntc_div.sv -----
// ----------------------------------------------------------------------------
// ntc_div: shared restoring divider
// One quotient bit per cycle; the caller gives the number of quotient bits.
// ----------------------------------------------------------------------------
module ntc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ntc_pkg::div_req_t          req_i,
  input  logic [ntc_pkg::R_W-1:0]    dividend_i,
  input  logic [ntc_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [ntc_pkg::R_W-1:0]    quotient_o
);
  import ntc_pkg::*;

  logic             run_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [R_W-1:0]   quo_q, quo_d;
  logic [DIV_W-1:0] dsr_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic             load;

  assign load  = req_i.go && !run_q;
  assign trial = {rem_q, quo_q[R_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    if (load) begin
      // preload the partial remainder with the bits above the quotient
      rem_d = DIV_W'(dividend_i >> req_i.steps);
      quo_d = dividend_i << (CNT_W'(R_W) - req_i.steps);
    end else if (run_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_d = {quo_q[R_W-2:0], ge};
    end else begin
      rem_d = rem_q;
      quo_d = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (load) begin
        run_q <= 1'b1;
        cnt_q <= req_i.steps;
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (load) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/ntc_regs.sv -----
// ----------------------------------------------------------------------------
// ntc_regs: APB configuration registers
// temp_start, temp_step and series_resistance, word addressed.
// ----------------------------------------------------------------------------
module ntc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ntc_pkg::APB_AW-1:0]  paddr,
  input  logic [ntc_pkg::APB_DW-1:0]  pwdata,
  output logic [ntc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output ntc_pkg::cfg_t               cfg_o
);
  import ntc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_start <= TEMP_START_RST;
      cfg_q.temp_step  <= TEMP_STEP_RST;
      cfg_q.series_res <= SERIES_RES_RST;
    end else if (wr) begin
      case (idx)
        REG_TEMP_START: cfg_q.temp_start <= pwdata[START_W-1:0];
        REG_TEMP_STEP:  cfg_q.temp_step  <= pwdata[STEP_W-1:0];
        REG_SERIES_RES: cfg_q.series_res <= pwdata[SRES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEMP_START: prdata = {{(APB_DW-START_W){1'b0}}, cfg_q.temp_start};
      REG_TEMP_STEP:  prdata = {{(APB_DW-STEP_W){1'b0}}, cfg_q.temp_step};
      REG_SERIES_RES: prdata = {{(APB_DW-SRES_W){1'b0}}, cfg_q.series_res};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ntc_checker.sv -----
// ----------------------------------------------------------------------------
// ntc_checker: port-level checks for the NTC ADC-to-temperature unit
// Command handshake and result strobe timing, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // each word passes S_MUL_R, S_SEL_R and S_CMP before its strobe, so strobes never sit back to back
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result word");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result word shown while still busy");

endmodule

bind ntc_adc_to_temperature_unit ntc_checker u_ntc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
